// File: sv/zotta_pkg.sv
// zotta_pkg: shared types and constants for the zero-offset trimmed-mean capture block.
// No dependencies; imported by every module of the block.
package zotta_pkg;

	localparam int SAMPLE_W        = 24;
	localparam int CAPTURE_SAMPLES = 30;
	localparam int AVERAGE_COUNT   = 4;
	localparam int TOP_DEPTH       = AVERAGE_COUNT + 1;
	localparam int CNT_W           = $clog2(CAPTURE_SAMPLES + 1);
	localparam int AVG_SHIFT       = $clog2(AVERAGE_COUNT);
	localparam int SUM_W           = SAMPLE_W + AVG_SHIFT;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// one input item
	typedef struct packed {
		logic    opcode;
		logic    arm;
		sample_t sample;
	} item_t;

	// sorted list, entry 0 is the largest
	typedef logic [TOP_DEPTH-1:0][SAMPLE_W-1:0] top_list_t;

	// list stage to mean stage
	typedef struct packed {
		logic fire;
	} mean_ctrl_t;

endpackage

// File: sv/zero_offset_trimmed_top_average_top.sv
// zero_offset_trimmed_top_average_top: zero-offset capture, trimmed mean of the top samples.
// Depends on zotta_pkg, zotta_top_list, zotta_mean.
//
//  channel | ports                               | transfer when
//  --------+-------------------------------------+---------------------------
//  item in | start, busy, opcode, arm, sample    | start && !busy at clk rise
//  result  | done, zero_value                    | done high (one cycle)
//
// One item is taken every cycle while busy is low; busy is high only in the first
// cycle after reset release. An item passes through the input register, the
// sorted insert (five parallel compares) then updates the list and the fire
// flag, and the adder for the four trimmed entries feeds the result register,
// which is loaded together with done from the fire flag set by the thirtieth
// sample's transfer. The receiver cannot stall; done is a single-cycle
// strobe. Reset is asynchronous, active low, and fills the list with the most
// negative sample value.
module zero_offset_trimmed_top_average_top
	import zotta_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  logic    opcode,
	input  logic    arm,
	input  sample_t sample,
	output logic    done,
	output sample_t zero_value
);

	logic       busy_q;
	logic       item_vld_s1;
	item_t      item_s1;
	top_list_t  top_list;
	mean_ctrl_t mean_ctrl;

	// hold off the first cycle after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			item_vld_s1 <= 1'b0;
		end else begin
			busy_q      <= 1'b0;
			item_vld_s1 <= start && !busy_q;
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			item_s1.opcode <= opcode;
			item_s1.arm    <= arm;
			item_s1.sample <= sample;
		end
	end

	assign busy = busy_q;

	zotta_top_list u_list (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_vld_s1 (item_vld_s1),
		.item_s1     (item_s1),
		.top_list    (top_list),
		.mean_ctrl   (mean_ctrl)
	);

	zotta_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.top_list   (top_list),
		.mean_ctrl  (mean_ctrl),
		.done       (done),
		.zero_value (zero_value)
	);

endmodule

// File: sv/zotta_top_list.sv
// zotta_top_list: sorted register list of the largest samples, sample counter and arm flag.
// Depends on zotta_pkg.
module zotta_top_list
	import zotta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_vld_s1,
	input  item_t      item_s1,
	output top_list_t  top_list,
	output mean_ctrl_t mean_ctrl
);

	top_list_t            top_q;
	top_list_t            top_ins;
	logic [TOP_DEPTH-1:0] gt;
	logic [CNT_W-1:0]     count_q;
	logic                 armed_q;
	logic                 fire_q;
	logic                 take;
	logic                 last;

	// gt is monotone over a descending list; an equal sample lands below equal entries
	always_comb begin
		for (int i = 0; i < TOP_DEPTH; i++) begin
			gt[i] = item_s1.sample > $signed(top_q[i]);
		end
		top_ins[0] = gt[0] ? item_s1.sample : top_q[0];
		for (int i = 1; i < TOP_DEPTH; i++) begin
			if (gt[i-1]) begin
				top_ins[i] = top_q[i-1];
			end else if (gt[i]) begin
				top_ins[i] = item_s1.sample;
			end else begin
				top_ins[i] = top_q[i];
			end
		end
	end

	assign take = item_vld_s1 && (item_s1.opcode == OP_SAMPLE) && armed_q;
	assign last = count_q == CNT_W'(CAPTURE_SAMPLES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= {TOP_DEPTH{SAMPLE_MIN}};
			count_q <= '0;
			armed_q <= 1'b0;
			fire_q  <= 1'b0;
		end else begin
			fire_q <= take && last;
			if (item_vld_s1 && item_s1.opcode == OP_RESTART) begin
				top_q   <= {TOP_DEPTH{SAMPLE_MIN}};
				count_q <= '0;
				armed_q <= item_s1.arm;
			end else if (take) begin
				top_q   <= top_ins;
				count_q <= count_q + 1'b1;
				if (last) begin
					armed_q <= 1'b0;
				end
			end
		end
	end

	assign top_list       = top_q;
	assign mean_ctrl.fire = fire_q;

endmodule

// File: sv/zotta_mean.sv
// zotta_mean: sums entries 1..AVERAGE_COUNT of the top list and registers the floor mean.
// Depends on zotta_pkg.
module zotta_mean
	import zotta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  top_list_t  top_list,
	input  mean_ctrl_t mean_ctrl,
	output logic       done,
	output sample_t    zero_value
);

	logic signed [SUM_W-1:0] sum;
	logic                    done_q;
	sample_t                 zero_value_q;

	always_comb begin
		sum = '0;
		for (int i = 1; i < TOP_DEPTH; i++) begin
			sum = sum + SUM_W'($signed(top_list[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mean_ctrl.fire;
		end
	end

	// arithmetic shift of the sum: floor division by the average count
	always_ff @(posedge clk) begin
		if (mean_ctrl.fire) begin
			zero_value_q <= sum[SUM_W-1:AVG_SHIFT];
		end
	end

	assign done       = done_q;
	assign zero_value = zero_value_q;

endmodule

// File: sv/zotta_checker.sv
// zotta_checker: port-level checks for the zero-offset capture block, bound to the top level.
// Depends on zotta_pkg and zero_offset_trimmed_top_average_top.
module zotta_checker
	import zotta_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    opcode,
	input logic    arm,
	input sample_t sample,
	input logic    done,
	input sample_t zero_value
);

	// a capture needs many samples, so results never come in adjacent cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> ##1 !done)
		else $error("results too close together");

	// every result follows a sample transfer by a fixed latency
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && opcode == OP_SAMPLE, 3))
		else $error("result without a sample transfer three cycles earlier");

	a_item_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown({opcode, arm, sample}))
		else $error("unknown item fields at a transfer");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(zero_value))
		else $error("unknown zero_value with done");

endmodule

bind zero_offset_trimmed_top_average_top zotta_checker u_zotta_checker (.*);
